// ----- sv/qwkd_pkg.sv -----
package qwkd_pkg;

   // Default sizes of the history window and the keyword set.
   localparam int WINDOW_BYTES_DEF  = 13;
   localparam int KEYWORD_COUNT_DEF = 6;

   // Keyword table. A keyword is stored as a string literal, so its last
   // character sits in the low byte; character i counted back from the
   // end of the keyword is KW_TEXT[k][8*i +: 8].
   localparam int KW_TABLE_SIZE = 6;
   localparam int KW_MAX_LEN    = 13;

   localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_TABLE_SIZE] = '{
      "CREATE",
      "MERGE",
      "SET",
      "DELETE",
      "DETACH DELETE",
      "REMOVE"
   };

   localparam int KW_LEN [KW_TABLE_SIZE] = '{6, 5, 3, 6, 13, 6};

   // Characters that the lexer reacts to.
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Byte that waits for the second half of a two-byte remark marker.
   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_SLASH = 2'd1,
      PEND_STAR  = 2'd2
   } pend_type;

   // One window entry: a text byte and whether a keyword may start there.
   typedef struct packed {
      logic [7:0] text;
      logic       elig;
   } cell_type;

   // Folds an ASCII lower-case letter to upper case.
   function automatic logic [7:0] fold_upper(input logic [7:0] b);
      if (b >= 8'h61 && b <= 8'h7A) begin
         return b - 8'h20;
      end
      return b;
   endfunction

endpackage

// ----- sv/qwkd_lexer.sv -----
module qwkd_lexer
   import qwkd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_byte,
   input  logic       last_byte,
   output logic       elig
);

   logic     quoted_ff, quoted_in;
   logic     line_ff, line_in;
   logic     block_ff, block_in;
   pend_type pend_ff, pend_in;
   logic     consumed;
   logic     is_quote;

   // Two-byte markers are resolved one byte late: the pending mark tells
   // whether the current byte can complete a marker.
   always_comb begin
      consumed  = 1'b0;
      quoted_in = quoted_ff;
      line_in   = line_ff;
      block_in  = block_ff;
      pend_in   = PEND_NONE;
      elig      = 1'b0;
      is_quote  = (text_byte == CH_SQUOTE) || (text_byte == CH_DQUOTE);

      unique case (pend_ff)
         PEND_SLASH: begin
            if (text_byte == CH_SLASH && !quoted_ff && !block_ff) begin
               line_in  = 1'b1;
               consumed = 1'b1;
            end else if (text_byte == CH_STAR && !quoted_ff && !line_ff) begin
               block_in = 1'b1;
               consumed = 1'b1;
            end
         end
         PEND_STAR: begin
            if (text_byte == CH_SLASH && block_ff) begin
               block_in = 1'b0;
               consumed = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (!consumed) begin
         if (is_quote && !line_ff && !block_ff) begin
            quoted_in = !quoted_ff;
         end else if (text_byte == CH_SLASH && !last_byte &&
                      ((!quoted_ff && !block_ff) || (!quoted_ff && !line_ff))) begin
            pend_in = PEND_SLASH;
         end else if (line_ff && text_byte == CH_NEWLINE) begin
            line_in = 1'b0;
         end else if (block_ff && text_byte == CH_STAR && !last_byte) begin
            pend_in = PEND_STAR;
         end else begin
            elig = !quoted_ff && !line_ff && !block_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         quoted_ff <= 1'b0;
         line_ff   <= 1'b0;
         block_ff  <= 1'b0;
         pend_ff   <= PEND_NONE;
      end else if (accept) begin
         quoted_ff <= quoted_in;
         line_ff   <= line_in;
         block_ff  <= block_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

// ----- sv/qwkd_cell.sv -----
module qwkd_cell
   import qwkd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  logic     clear,
   input  cell_type data_in,
   output cell_type data_out
);

   logic [7:0] text_ff;
   logic       elig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         elig_ff <= 1'b0;
      end else if (shift_en) begin
         text_ff <= data_in.text;
         elig_ff <= clear ? 1'b0 : data_in.elig;
      end
   end

   assign data_out = '{text: text_ff, elig: elig_ff};

endmodule

// ----- sv/query_write_keyword_detector_core.sv -----
// Write-keyword detector. A query text streams in one byte per request,
// the final byte marked by req_last_byte. The block follows quoted strings
// (either quote kind), line remarks from a double slash to a newline and
// block remarks between slash-star and star-slash, and reports on rsp_is_write
// whether CREATE, MERGE, SET, DELETE, DETACH DELETE or REMOVE, compared
// without regard to letter case, begins at a byte that lies outside strings
// and remarks. Exactly one response comes per query, in the cycle after its
// last byte is accepted, and the lexer state, the write flag and the start
// flags then return to reset so the next byte begins a new query. A request
// is accepted every cycle: the lexer and the keyword compare over the byte
// window are combinational and the response sits in an output register, so
// the only back-pressure is a response held there while rsp_stall is high.
module query_write_keyword_detector_core
   import qwkd_pkg::*;
#(
   parameter int WINDOW_BYTES  = WINDOW_BYTES_DEF,
   parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_write
);

   // The newest byte comes straight from the request, so the chain only
   // keeps the WINDOW_BYTES - 1 bytes before it.
   localparam int CELL_COUNT = WINDOW_BYTES - 1;

   logic     accept;
   logic     last_accept;
   logic     elig_now;
   logic     hit;
   logic     write_seen_ff;
   logic     rsp_valid_ff;
   logic     rsp_is_write_ff;
   logic     [KW_TABLE_SIZE-1:0] kw_hit;
   cell_type cell_data [CELL_COUNT];
   cell_type win [WINDOW_BYTES];

   // A new request waits only while a finished response is held back.
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign last_accept = accept && req_last_byte;

   // The lexer decides whether the incoming byte may start a keyword.
   qwkd_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .last_byte (req_last_byte),
      .elig      (elig_now)
   );

   // The window as it stands once this byte is taken: entry 0 is the new
   // byte, entry i the byte accepted i requests earlier.
   assign win[0] = '{text: req_text_byte, elig: elig_now};

   // Shift chain of window cells. Each cell takes its neighbor's entry on
   // every accepted request; the last byte of a query clears the start
   // flags so that nothing reaches into the following query.
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      qwkd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .clear    (req_last_byte),
         .data_in  (win[i]),
         .data_out (cell_data[i])
      );
      assign win[i+1] = cell_data[i];
   end

   // A keyword ends at the incoming byte when its first character sits at
   // a flagged start and every character matches after case folding.
   for (genvar k = 0; k < KW_TABLE_SIZE; k++) begin : g_kw
      if (k < KEYWORD_COUNT && KW_LEN[k] <= WINDOW_BYTES) begin : g_on
         logic [KW_MAX_LEN-1:0] char_ok;
         for (genvar i = 0; i < KW_MAX_LEN; i++) begin : g_char
            if (i < KW_LEN[k]) begin : g_cmp
               assign char_ok[i] = fold_upper(win[i].text) == KW_TEXT[k][8*i +: 8];
            end else begin : g_pad
               assign char_ok[i] = 1'b1;
            end
         end
         assign kw_hit[k] = win[KW_LEN[k]-1].elig && (&char_ok);
      end else begin : g_off
         assign kw_hit[k] = 1'b0;
      end
   end

   assign hit = |kw_hit;

   // Sticky write flag for the query in flight.
   always_ff @(posedge clock) begin
      if (reset || last_accept) begin
         write_seen_ff <= 1'b0;
      end else if (accept && hit) begin
         write_seen_ff <= 1'b1;
      end
   end

   // Output register for the one response of each query.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_accept) begin
         rsp_is_write_ff <= write_seen_ff || hit;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_write = rsp_is_write_ff;

   // A response appears only after the last byte of a query was taken.
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(last_accept))
      else $error("response raised without a last byte");

   // The write flag starts every query cleared.
   a_flag_cleared: assert property (@(posedge clock) disable iff (reset)
      last_accept |=> !write_seen_ff)
      else $error("write flag carried into the next query");

   // A quote byte always toggles or sits in a remark; it never starts a keyword.
   a_quote_not_start: assert property (@(posedge clock) disable iff (reset)
      (accept && elig_now) |->
         (req_text_byte != CH_SQUOTE && req_text_byte != CH_DQUOTE))
      else $error("quote byte flagged as keyword start");

   // A response held under stall blocks new requests.
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !accept)
      else $error("request accepted while response held");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the write-keyword detector.
//
// Query texts are streamed into the block one byte per request, with the
// final byte of each query marked by req_last_byte. A scoreboard model in
// this file follows the same lexer (quoted strings, line remarks and block
// remarks, with the two-byte markers resolved one byte late) and the same
// keyword window. Each time a query's last byte is accepted, the model
// pushes its verdict, and every response from the block is compared
// against the oldest verdict that is still waiting.
//
// The run has three parts. The first sends single-byte queries at the ends
// of the byte range. The second sends short queries that exercise the
// lexer corner cases. The third sends random queries built from keyword
// tokens, near misses, quotes, remark markers and raw bytes. The sender
// works in bursts with random gaps. The receiver stalls according to a
// pattern that is picked anew at random during the run.
module tb_top
   import qwkd_pkg::*;
();

   // Number of request bytes to send in the random part.
   localparam int QUERY_BYTES = 850;

   // Cycles to wait after the last verdict has been matched. The block
   // answers in the cycle after the last byte, so this is generous.
   localparam int SETTLE_CYCLES = 8;

   // Kinds of text fragments from which the random queries are assembled.
   typedef enum {
      TOK_KEYWORD,
      TOK_NEAR_MISS,
      TOK_BLANK,
      TOK_WORD,
      TOK_QUOTE,
      TOK_LINE_OPEN,
      TOK_BLOCK_OPEN,
      TOK_BLOCK_CLOSE,
      TOK_NEWLINE,
      TOK_SLASH,
      TOK_STAR,
      TOK_RAW
   } token_kind_type;

   // Response-side stall patterns.
   typedef enum {
      STALL_NONE,
      STALL_RANDOM,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic       rsp_is_write;

   query_write_keyword_detector_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_write  (rsp_is_write)
   );

   always #1 clock = ~clock;

   // -----------------------------------------------------------------
   // Scoreboard model of the lexer and keyword window.
   // -----------------------------------------------------------------

   logic       lex_quoted;
   logic       lex_line;
   logic       lex_block;
   pend_type   lex_pend;
   logic [7:0] hist_text  [WINDOW_BYTES_DEF];
   logic       hist_start [WINDOW_BYTES_DEF];
   logic       write_found;

   // Verdicts predicted for queries whose last byte has been accepted.
   logic       verdict_queue [$];

   int         mismatch_count = 0;
   int         bytes_sent     = 0;

   // Whether the sender inserts gaps, and how many requests remain in the
   // current burst.
   bit         gaps_on    = 1'b1;
   int         burst_left = 0;

   // Text of the query that is being assembled.
   logic [7:0] query_text [$];

   function automatic logic [7:0] upcase(input logic [7:0] b);
      if (b >= "a" && b <= "z") begin
         return b & 8'hDF;
      end
      return b;
   endfunction

   task automatic clear_lexer();
      lex_quoted  = 1'b0;
      lex_line    = 1'b0;
      lex_block   = 1'b0;
      lex_pend    = PEND_NONE;
      write_found = 1'b0;
      for (int i = 0; i < WINDOW_BYTES_DEF; i++) begin
         hist_text[i]  = 8'h00;
         hist_start[i] = 1'b0;
      end
   endtask

   // Advances the model by one accepted byte. On the last byte of a query,
   // the verdict is queued and the model returns to its reset state.
   task automatic predict_byte(input logic [7:0] b, input logic is_last);
      logic taken;
      logic start_here;
      logic hit;
      int   len;
      taken      = 1'b0;
      start_here = 1'b0;

      // Resolve a pending slash or star against this byte first.
      case (lex_pend)
         PEND_SLASH: begin
            if (b == CH_SLASH && !lex_quoted && !lex_block) begin
               lex_line = 1'b1;
               taken    = 1'b1;
            end else if (b == CH_STAR && !lex_quoted && !lex_line) begin
               lex_block = 1'b1;
               taken     = 1'b1;
            end
         end
         PEND_STAR: begin
            if (b == CH_SLASH && lex_block) begin
               lex_block = 1'b0;
               taken     = 1'b1;
            end
         end
         default: begin
         end
      endcase
      lex_pend = PEND_NONE;

      if (!taken) begin
         if ((b == CH_SQUOTE || b == CH_DQUOTE) && !lex_line && !lex_block) begin
            lex_quoted = !lex_quoted;
         end else if (b == CH_SLASH && !is_last &&
                      ((!lex_quoted && !lex_block) || (!lex_quoted && !lex_line))) begin
            lex_pend = PEND_SLASH;
         end else if (lex_line && b == CH_NEWLINE) begin
            lex_line = 1'b0;
         end else if (lex_block && b == CH_STAR && !is_last) begin
            lex_pend = PEND_STAR;
         end else begin
            start_here = !lex_quoted && !lex_line && !lex_block;
         end
      end

      for (int i = WINDOW_BYTES_DEF - 1; i > 0; i--) begin
         hist_text[i]  = hist_text[i-1];
         hist_start[i] = hist_start[i-1];
      end
      hist_text[0]  = b;
      hist_start[0] = start_here;

      // Entry 0 holds the newest byte, which lines up with the low byte of
      // each keyword string, so entry i is compared with the character i
      // places back from the end of the keyword.
      for (int k = 0; k < KEYWORD_COUNT_DEF && k < KW_TABLE_SIZE; k++) begin
         len = KW_LEN[k];
         if (len > 0 && len <= WINDOW_BYTES_DEF && hist_start[len-1]) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
               if (upcase(hist_text[i]) != KW_TEXT[k][8*i +: 8]) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               write_found = 1'b1;
            end
         end
      end

      if (is_last) begin
         verdict_queue.push_back(write_found);
         clear_lexer();
      end
   endtask

   // -----------------------------------------------------------------
   // Response checking.
   // -----------------------------------------------------------------

   logic want_write;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_queue.size() == 0) begin
            $error("is_write: expected no response, got %0d", rsp_is_write);
            mismatch_count++;
         end else begin
            want_write = verdict_queue.pop_front();
            if (rsp_is_write !== want_write) begin
               $error("is_write: expected %0d, got %0d", want_write, rsp_is_write);
               mismatch_count++;
            end
         end
      end
   end

   // -----------------------------------------------------------------
   // Receiver stall pattern, picked anew at random as stall_tick advances.
   // STALL_NONE gives long stretches where responses drain freely.
   // -----------------------------------------------------------------

   int             stall_tick = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always @(posedge clock) begin
      stall_tick++;
      if (stall_tick % 48 == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:  rsp_stall <= (stall_tick % 8 != 0);
         default:      rsp_stall <= (stall_tick % 2 == 1);
      endcase
   end

   // -----------------------------------------------------------------
   // Request side.
   // -----------------------------------------------------------------

   // Sends one byte and waits until it is accepted. Valid is left high when
   // the burst continues, so the next call raises it again without a drop in
   // between. At the end of a burst, valid is dropped for a random gap before
   // the task returns.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= is_last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_byte(b, is_last);
      bytes_sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_query(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], i == s.len() - 1);
      end
   endtask

   // Holds the sender off until every predicted verdict has been matched.
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (verdict_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Flips the case of a letter at random, so that the keyword compare is
   // exercised with every mix of upper and lower case.
   function automatic logic [7:0] jumble_case(input logic [7:0] b);
      if ((b | 8'h20) >= "a" && (b | 8'h20) <= "z" && $urandom_range(0, 1) == 1) begin
         return b ^ 8'h20;
      end
      return b;
   endfunction

   // Appends a keyword from the table. A near miss drops the final letter.
   task automatic add_keyword(input bit near_miss);
      int k;
      k = $urandom_range(0, KW_TABLE_SIZE - 1);
      for (int i = KW_LEN[k] - 1; i >= (near_miss ? 1 : 0); i--) begin
         query_text.push_back(jumble_case(KW_TEXT[k][8*i +: 8]));
      end
   endtask

   task automatic add_token();
      int             r;
      token_kind_type kind;
      r = $urandom_range(0, 15);
      // Keywords are drawn more often than any other fragment.
      kind = (r < 4) ? TOK_KEYWORD : token_kind_type'(r - 4);
      case (kind)
         TOK_KEYWORD:     add_keyword(1'b0);
         TOK_NEAR_MISS:   add_keyword(1'b1);
         TOK_BLANK:       query_text.push_back($urandom_range(0, 1) ? " " : "(");
         TOK_WORD: begin
            repeat ($urandom_range(1, 4)) begin
               query_text.push_back(jumble_case(8'($urandom_range("a", "z"))));
            end
         end
         TOK_QUOTE:       query_text.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
         TOK_LINE_OPEN: begin
            query_text.push_back(CH_SLASH);
            query_text.push_back(CH_SLASH);
         end
         TOK_BLOCK_OPEN: begin
            query_text.push_back(CH_SLASH);
            query_text.push_back(CH_STAR);
         end
         TOK_BLOCK_CLOSE: begin
            query_text.push_back(CH_STAR);
            query_text.push_back(CH_SLASH);
         end
         TOK_NEWLINE:     query_text.push_back(CH_NEWLINE);
         TOK_SLASH:       query_text.push_back(CH_SLASH);
         TOK_STAR:        query_text.push_back(CH_STAR);
         default:         query_text.push_back(8'($urandom_range(0, 255)));
      endcase
   endtask

   // -----------------------------------------------------------------
   // Tests.
   // -----------------------------------------------------------------

   // Single-byte queries at both ends of the byte range.
   task automatic test_byte_extremes();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
   endtask

   // Short queries aimed at the lexer corner cases: a keyword in mixed
   // case, a slash that cannot pair because it is the last byte, a keyword
   // hidden in a string, and keywords that follow a closed block remark and
   // a line remark ended by a newline. The remark markers are consumed
   // without opening a keyword start.
   task automatic test_lexer_cases();
      send_query("sEt");
      send_query("/");
      send_query("'set");
      send_query("/*x*/set");
      send_query("//s\nset");
   endtask

   // Random queries of one to ten fragments. Some queries end on a bare
   // slash or star, so that a marker is split by the last byte. Partway
   // through, the sender is held off until every response has arrived.
   task automatic test_random_queries();
      int  target;
      bit  drained;
      target  = bytes_sent + QUERY_BYTES;
      drained = 1'b0;
      gaps_on = 1'b0;
      while (bytes_sent < target) begin
         // Random sender gaps are turned on after a first stretch without.
         if (bytes_sent > target - QUERY_BYTES + 120) begin
            gaps_on = ($urandom_range(0, 4) != 0);
         end
         query_text.delete();
         repeat ($urandom_range(1, 10)) add_token();
         if ($urandom_range(0, 7) == 0) begin
            query_text.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
         end
         for (int i = 0; i < query_text.size(); i++) begin
            send_byte(query_text[i], i == query_text.size() - 1);
         end
         if (!drained && bytes_sent > target - QUERY_BYTES / 2) begin
            wait_all_responses();
            drained = 1'b1;
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      clear_lexer();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_byte_extremes();
      wait_all_responses();
      test_lexer_cases();
      wait_all_responses();
      test_random_queries();
      wait_all_responses();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Safety net in case the block stops answering.
   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
